>>> rtl/lvm_pkg.sv
`timescale 1ns / 1ps
package lvm_pkg;
   localparam int VoicesDefault = 8;
   localparam int SampleWordsDefault = 65536;
   localparam logic [15:0] RepeatForever = 16'hFFFF;
   typedef enum logic [1:0] {
      REQ_WRITE = 2'd0,
      REQ_PLAY  = 2'd1,
      REQ_MIX   = 2'd2,
      REQ_NONE  = 2'd3
   } req_type_type;
endpackage

>>> rtl/looping_voice_mixer.sv
`timescale 1ns / 1ps
// Stereo sample mixer. A request is taken while busy is low; exactly one response follows,
// shown for one cycle under rsp_valid, and it cannot be held off. A write or a play request
// passes through its own state and then the done state before the mixer is idle again; an
// unused request type goes straight to the done state. A mix request visits every voice in
// turn through the voice memory and the sample memory, in the states VREAD, SREAD, MUL and
// ACC for each voice, and then goes to the done state.
// The sample memory has no reset; words never written read as anything.
module looping_voice_mixer
   import lvm_pkg::*;
#(
   parameter int VOICES = VoicesDefault,
   parameter int SAMPLE_WORDS = SampleWordsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [15:0] req_sample_addr,
   input  logic signed [15:0] req_sample_value,
   input  logic [15:0] req_start_addr,
   input  logic [15:0] req_end_addr,
   input  logic [15:0] req_repeat_count,
   input  logic [15:0] req_volume_left,
   input  logic [15:0] req_volume_right,
   output logic        rsp_valid,
   output logic        rsp_accepted,
   output logic [2:0]  rsp_voice_index,
   output logic signed [15:0] rsp_left_out,
   output logic signed [15:0] rsp_right_out,
   output logic [7:0]  rsp_finished_voices
);
   localparam int VW = $clog2(VOICES);
   localparam int AW = $clog2(SAMPLE_WORDS);

   typedef struct packed {
      logic [15:0] pos;
      logic [15:0] st;
      logic [15:0] en;
      logic [15:0] rep;
      logic [15:0] gl;
      logic [15:0] gr;
   } voice_type;

   typedef enum logic [2:0] {
      S_IDLE, S_WRITE, S_PLAY, S_VREAD, S_SREAD, S_MUL, S_ACC, S_DONE
   } state_type;

   logic [15:0] sample_mem [SAMPLE_WORDS];
   voice_type voice_mem [VOICES];

   state_type state_ff;
   logic [VOICES-1:0] stopped_ff;
   logic [VOICES-1:0] link_valid_ff;
   logic [VW-1:0] link_ff [VOICES];
   logic [VW-1:0] head_ff, tail_ff;
   logic [VW-1:0] v_ff;
   logic [1:0] req_ff;
   logic [15:0] a_addr_ff, a_val_ff, a_st_ff, a_en_ff, a_rep_ff, a_gl_ff, a_gr_ff;
   voice_type vrd_ff;
   logic [15:0] sl_ff, sr_ff;
   logic signed [31:0] pl_ff, pr_ff;
   logic [15:0] left_ff, right_ff;
   logic [7:0] fin_ff;
   logic rsp_valid_ff, rsp_acc_ff;
   logic [2:0] rsp_idx_ff;
   logic [15:0] rsp_l_ff, rsp_r_ff;
   logic [7:0] rsp_f_ff;
   logic adv_ff;

   logic [AW-1:0] rd_l, rd_r;
   logic [16:0] next_pos;
   logic empty_snd, wrap, rep_forever, stops;
   voice_type vwb;
   logic signed [31:0] ql, qr;

   assign rd_l = AW'(vrd_ff.pos);
   assign rd_r = AW'(vrd_ff.pos + 16'd1);
   assign empty_snd = vrd_ff.pos >= vrd_ff.en;
   assign next_pos = {1'b0, vrd_ff.pos} + 17'd2;
   assign wrap = empty_snd || (next_pos >= {1'b0, vrd_ff.en});
   assign rep_forever = vrd_ff.rep == RepeatForever;
   assign stops = wrap && !rep_forever && (vrd_ff.rep <= 16'd1);
   assign ql = pl_ff / 32'sd16384;
   assign qr = pr_ff / 32'sd16384;

   always_comb begin
      vwb = vrd_ff;
      if (wrap) begin
         vwb.pos = vrd_ff.st;
         if (stops) begin
            vwb.rep = 16'd0;
         end else if (!rep_forever) begin
            vwb.rep = vrd_ff.rep - 16'd1;
         end
      end else begin
         vwb.pos = next_pos[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_WRITE) begin
         sample_mem[AW'(a_addr_ff)] <= a_val_ff;
      end
      sl_ff <= sample_mem[rd_l];
      sr_ff <= sample_mem[rd_r];
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_PLAY && link_valid_ff[head_ff]) begin
         voice_mem[head_ff] <= '{pos: a_st_ff, st: a_st_ff, en: a_en_ff, rep: a_rep_ff,
                                 gl: a_gl_ff, gr: a_gr_ff};
      end else if (state_ff == S_SREAD) begin
         voice_mem[v_ff] <= vwb;
      end
      vrd_ff <= voice_mem[v_ff];
   end

   always_ff @(posedge clock) begin
      pl_ff <= $signed(sl_ff) * $signed({1'b0, vrd_ff.gl});
      pr_ff <= $signed(sr_ff) * $signed({1'b0, vrd_ff.gr});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         stopped_ff <= '1;
         for (int i = 0; i < VOICES; i++) begin
            link_ff[i] <= VW'(i + 1);
            link_valid_ff[i] <= (i + 1 < VOICES);
         end
         head_ff <= '0;
         tail_ff <= VW'(VOICES - 1);
         rsp_valid_ff <= 1'b0;
         v_ff <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  req_ff <= req_type;
                  a_addr_ff <= req_sample_addr;
                  a_val_ff <= req_sample_value;
                  a_st_ff <= req_start_addr;
                  a_en_ff <= req_end_addr;
                  a_rep_ff <= req_repeat_count;
                  a_gl_ff <= req_volume_left;
                  a_gr_ff <= req_volume_right;
                  left_ff <= '0;
                  right_ff <= '0;
                  fin_ff <= '0;
                  v_ff <= '0;
                  case (req_type)
                     REQ_WRITE: state_ff <= S_WRITE;
                     REQ_PLAY: state_ff <= S_PLAY;
                     REQ_MIX: state_ff <= S_VREAD;
                     default: state_ff <= S_DONE;
                  endcase
               end
            end
            S_WRITE: state_ff <= S_DONE;
            S_PLAY: begin
               if (link_valid_ff[head_ff]) begin
                  stopped_ff[head_ff] <= 1'b0;
                  head_ff <= link_ff[head_ff];
               end
               state_ff <= S_DONE;
            end
            S_VREAD: state_ff <= S_SREAD;
            S_SREAD: begin
               adv_ff <= !stopped_ff[v_ff] && !empty_snd;
               if (!stopped_ff[v_ff] && stops) begin
                  stopped_ff[v_ff] <= 1'b1;
                  link_valid_ff[v_ff] <= 1'b0;
                  link_ff[tail_ff] <= v_ff;
                  link_valid_ff[tail_ff] <= 1'b1;
                  tail_ff <= v_ff;
                  if (32'(v_ff) < 8) begin
                     fin_ff[3'(v_ff)] <= 1'b1;
                  end
               end
               state_ff <= S_MUL;
            end
            S_MUL: state_ff <= S_ACC;
            S_ACC: begin
               if (adv_ff) begin
                  left_ff <= left_ff + ql[15:0];
                  right_ff <= right_ff + qr[15:0];
               end
               if (32'(v_ff) == VOICES - 1) begin
                  state_ff <= S_DONE;
               end else begin
                  v_ff <= v_ff + VW'(1);
                  state_ff <= S_VREAD;
               end
            end
            S_DONE: begin
               rsp_valid_ff <= 1'b1;
               rsp_acc_ff <= 1'b0;
               rsp_idx_ff <= '0;
               rsp_l_ff <= '0;
               rsp_r_ff <= '0;
               rsp_f_ff <= '0;
               case (req_ff)
                  REQ_WRITE: rsp_acc_ff <= 1'b1;
                  REQ_PLAY: begin
                     if (a_addr_ff[0]) begin
                        rsp_acc_ff <= 1'b1;
                        rsp_idx_ff <= a_addr_ff[3:1];
                     end
                  end
                  REQ_MIX: begin
                     rsp_l_ff <= left_ff;
                     rsp_r_ff <= right_ff;
                     rsp_f_ff <= fin_ff;
                  end
                  default: ;
               endcase
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
         if (state_ff == S_PLAY) begin
            a_addr_ff <= {12'd0, 3'(head_ff), link_valid_ff[head_ff]};
         end
      end
   end

   assign busy = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_accepted = rsp_acc_ff;
   assign rsp_voice_index = rsp_idx_ff;
   assign rsp_left_out = rsp_l_ff;
   assign rsp_right_out = rsp_r_ff;
   assign rsp_finished_voices = rsp_f_ff;
endmodule

>>> rtl/lvm_checker.sv
`timescale 1ns / 1ps
module lvm_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_accepted,
   input logic [2:0] rsp_voice_index,
   input logic [15:0] rsp_left_out,
   input logic [7:0] rsp_finished_voices
);
   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("request taken without going busy");
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response shown twice");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("response while busy");
   a_idx: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_accepted) |-> (rsp_voice_index == 3'd0))
      else $error("index on refused request");
   a_fin: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_accepted) |-> (rsp_finished_voices == 8'd0 && rsp_left_out == 16'd0))
      else $error("mix data on accepted request");
endmodule

bind looping_voice_mixer lvm_checker u_lvm_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .rsp_valid(rsp_valid),
   .rsp_accepted(rsp_accepted), .rsp_voice_index(rsp_voice_index),
   .rsp_left_out(rsp_left_out), .rsp_finished_voices(rsp_finished_voices)
);

>>> test/looping_voice_mixer_tb.sv
`timescale 1ns / 1ps
module looping_voice_mixer_tb;
   import lvm_pkg::*;

   typedef struct {
      req_type_type kind;
      logic [15:0] addr;
      logic [15:0] value;
      logic [15:0] first;
      logic [15:0] last;
      logic [15:0] repeats;
      logic [15:0] gain_l;
      logic [15:0] gain_r;
      bit typed;
      bit acc;
      logic [2:0] idx;
   } request_type;

   typedef struct {
      bit acc;
      logic [2:0] idx;
      logic [15:0] left;
      logic [15:0] right;
      logic [7:0] fin;
   } frame_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_type = REQ_NONE;
   logic [15:0] req_sample_addr = '0;
   logic signed [15:0] req_sample_value = '0;
   logic [15:0] req_start_addr = '0;
   logic [15:0] req_end_addr = '0;
   logic [15:0] req_repeat_count = '0;
   logic [15:0] req_volume_left = '0;
   logic [15:0] req_volume_right = '0;
   logic rsp_valid;
   logic rsp_accepted;
   logic [2:0] rsp_voice_index;
   logic signed [15:0] rsp_left_out;
   logic signed [15:0] rsp_right_out;
   logic [7:0] rsp_finished_voices;

   looping_voice_mixer uut (.*);

   always #5 clock = ~clock;

   // Model state of the mixer.
   logic [15:0] words [0:65535];
   bit written [0:65535];
   logic [15:0] pos_m [0:7];
   logic [15:0] first_m [0:7];
   logic [15:0] last_m [0:7];
   logic [15:0] reps_m [0:7];
   logic [15:0] gl_m [0:7];
   logic [15:0] gr_m [0:7];
   bit stopped_m [0:7];
   logic [2:0] link_m [0:7];
   bit link_ok [0:7];
   logic [2:0] free_head;
   logic [2:0] free_tail;

   frame_type expected_frames [$];
   int errors = 0;
   int items = 0;
   int idle = 0;
   int long_voices = 0;

   initial begin
      for (int v = 0; v < 8; v++) begin
         pos_m[v] = '0; first_m[v] = '0; last_m[v] = '0; reps_m[v] = '0;
         gl_m[v] = '0; gr_m[v] = '0; stopped_m[v] = 1'b1;
         link_m[v] = 3'(v + 1); link_ok[v] = (v < 7);
      end
      free_head = '0;
      free_tail = 3'd7;
   end

   function automatic logic [15:0] scaled(logic [15:0] word, logic [15:0] gain);
      int p;
      p = int'($signed(word)) * int'({16'd0, gain});
      p = p / 16384;
      return p[15:0];
   endfunction

   // Returns to the start point and spends a repeat; 1 when the voice stops.
   function automatic bit rewind(int v);
      pos_m[v] = first_m[v];
      if (reps_m[v] == RepeatForever) return 1'b0;
      if (reps_m[v] <= 16'd1) begin
         reps_m[v] = '0;
         stopped_m[v] = 1'b1;
         link_ok[v] = 1'b0;
         link_m[free_tail] = 3'(v);
         link_ok[free_tail] = 1'b1;
         free_tail = 3'(v);
         return 1'b1;
      end
      reps_m[v] = reps_m[v] - 16'd1;
      return 1'b0;
   endfunction

   function automatic frame_type mix_step(request_type q);
      frame_type f;
      int h;
      bit done;
      f = '{1'b0, 3'd0, 16'd0, 16'd0, 8'd0};
      case (q.kind)
         REQ_WRITE: begin
            words[q.addr] = q.value;
            written[q.addr] = 1'b1;
            f.acc = 1'b1;
         end
         REQ_PLAY: begin
            h = int'(free_head);
            if (link_ok[h]) begin
               first_m[h] = q.first; pos_m[h] = q.first; last_m[h] = q.last;
               reps_m[h] = q.repeats; gl_m[h] = q.gain_l; gr_m[h] = q.gain_r;
               stopped_m[h] = 1'b0;
               free_head = link_m[h];
               f.acc = 1'b1;
               f.idx = 3'(h);
            end
         end
         REQ_MIX: begin
            for (int v = 0; v < 8; v++) begin
               if (stopped_m[v]) continue;
               if (pos_m[v] >= last_m[v]) begin
                  done = rewind(v);
               end else begin
                  f.left = f.left + scaled(words[pos_m[v]], gl_m[v]);
                  f.right = f.right + scaled(words[16'(pos_m[v] + 16'd1)], gr_m[v]);
                  if (int'(pos_m[v]) + 2 >= int'(last_m[v])) begin
                     done = rewind(v);
                  end else begin
                     pos_m[v] = pos_m[v] + 16'd2;
                     done = 1'b0;
                  end
               end
               if (done) f.fin[v] = 1'b1;
            end
         end
         default: ;
      endcase
      return f;
   endfunction

   function automatic request_type row(req_type_type k, int a, int d, int s, int e, int r,
                                       int gl, int gr);
      request_type q;
      q.kind = k; q.addr = 16'(a); q.value = 16'(d); q.first = 16'(s); q.last = 16'(e);
      q.repeats = 16'(r); q.gain_l = 16'(gl); q.gain_r = 16'(gr);
      q.typed = 1'b0; q.acc = 1'b0; q.idx = '0;
      return q;
   endfunction

   function automatic request_type typed_row(request_type q, bit acc, int idx);
      q.typed = 1'b1; q.acc = acc; q.idx = 3'(idx);
      return q;
   endfunction

   task automatic issue(request_type q);
      frame_type f;
      int r;
      int gap;
      req_type <= q.kind;
      req_sample_addr <= q.addr;
      req_sample_value <= q.value;
      req_start_addr <= q.first;
      req_end_addr <= q.last;
      req_repeat_count <= q.repeats;
      req_volume_left <= q.gain_l;
      req_volume_right <= q.gain_r;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      f = mix_step(q);
      if (q.typed) f = '{q.acc, q.idx, 16'd0, 16'd0, 8'd0};
      expected_frames.push_back(f);
      items++;
      r = $urandom_range(0, 99);
      gap = r < 65 ? 0 : r < 95 ? $urandom_range(1, 3) : $urandom_range(10, 60);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic fill_range(int s, int e);
      for (int a = s; a <= e; a++)
         if (!written[a]) issue(row(REQ_WRITE, a, $urandom_range(0, 65535), 0, 0, 0, 0, 0));
   endtask

   always @(posedge clock) begin
      frame_type f;
      if (!reset && rsp_valid) begin
         if (expected_frames.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
         end else begin
            f = expected_frames.pop_front();
            if (rsp_accepted !== f.acc) begin
               $error("accepted: expected %0d, got %0d", f.acc, rsp_accepted);
               errors++;
            end
            if (rsp_voice_index !== f.idx) begin
               $error("voice_index: expected %0d, got %0d", f.idx, rsp_voice_index);
               errors++;
            end
            if (rsp_left_out !== f.left) begin
               $error("left_out: expected %h, got %h", f.left, rsp_left_out);
               errors++;
            end
            if (rsp_right_out !== f.right) begin
               $error("right_out: expected %h, got %h", f.right, rsp_right_out);
               errors++;
            end
            if (rsp_finished_voices !== f.fin) begin
               $error("finished_voices: expected %h, got %h", f.fin, rsp_finished_voices);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle <= 0;
      else idle <= idle + 1;
      if (idle > 4000) begin
         $display("looping_voice_mixer regression: fail");
         $finish;
      end
   end

   initial begin
      request_type plan [$];
      int r;
      int s;
      int e;
      int rep;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      plan.push_back(typed_row(row(REQ_MIX, 0, 0, 0, 0, 0, 0, 0), 0, 0));
      plan.push_back(typed_row(row(REQ_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                   16'hFFFF, 16'hFFFF, 16'hFFFF), 0, 0));
      plan.push_back(typed_row(row(REQ_WRITE, 0, 16'h7FFF, 0, 0, 0, 0, 0), 1, 0));
      plan.push_back(typed_row(row(REQ_WRITE, 1, 16'h8000, 0, 0, 0, 0, 0), 1, 0));
      plan.push_back(row(REQ_WRITE, 2, 16'hFFFF, 0, 0, 0, 0, 0));
      plan.push_back(row(REQ_WRITE, 3, 16'h0001, 0, 0, 0, 0, 0));
      plan.push_back(row(REQ_WRITE, 4, 16'h1234, 0, 0, 0, 0, 0));
      plan.push_back(row(REQ_WRITE, 16'hFFFE, 16'hC000, 0, 0, 0, 0, 0));
      plan.push_back(typed_row(row(REQ_WRITE, 16'hFFFF, 16'h4000, 0, 0, 0, 0, 0), 1, 0));
      plan.push_back(typed_row(row(REQ_PLAY, 0, 0, 0, 4, 1, 16'hFFFF, 16'hFFFF), 1, 0));
      plan.push_back(typed_row(row(REQ_PLAY, 0, 0, 10, 10, 2, 16'h4000, 16'h4000), 1, 1));
      plan.push_back(row(REQ_PLAY, 0, 0, 0, 3, 16'hFFFE, 16'h4000, 16'h0000));
      plan.push_back(row(REQ_PLAY, 0, 0, 16'hFFFE, 16'hFFFF, int'(RepeatForever), 16'h2000,
                         16'hFFFF));
      plan.push_back(row(REQ_PLAY, 0, 0, 2, 4, 0, 16'h0001, 16'h8000));
      plan.push_back(row(REQ_PLAY, 0, 0, 9, 3, 3, 16'h7FFF, 16'h3FFF));
      plan.push_back(typed_row(row(REQ_PLAY, 0, 0, 1, 4, 2, 16'hFFFF, 16'h0000), 1, 6));
      plan.push_back(typed_row(row(REQ_PLAY, 0, 0, 0, 4, 1, 16'h4000, 16'h4000), 0, 0));
      for (int i = 0; i < 6; i++) plan.push_back(row(REQ_MIX, 0, 0, 0, 0, 0, 0, 0));
      long_voices = 2;
      foreach (plan[i]) issue(plan[i]);

      while (items < 550) begin
         r = $urandom_range(0, 99);
         if (r < 8) begin
            issue(row(REQ_WRITE, $urandom_range(0, 65535), $urandom_range(0, 65535),
                      0, 0, 0, 0, 0));
         end else if (r < 13) begin
            issue(row(REQ_NONE, $urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535)));
         end else if (r < 20) begin
            issue(row(REQ_WRITE, $urandom_range(0, 511), $urandom_range(0, 65535),
                      0, 0, 0, 0, 0));
         end else if (r < 45) begin
            s = ($urandom_range(0, 9) == 0) ? $urandom_range(65500, 65535)
                                             : $urandom_range(0, 255);
            if ($urandom_range(0, 3) != 0) s = s & ~1;
            e = ($urandom_range(0, 9) == 0) ? s - $urandom_range(0, 5)
                                             : s + $urandom_range(1, 14);
            if (e > 65535) e = 65535;
            if (e < 0) e = 0;
            r = $urandom_range(0, 99);
            rep = r < 70 ? $urandom_range(1, 3) : r < 80 ? 0 : $urandom_range(4, 8);
            if (r >= 98 && long_voices < 3) begin
               rep = (r == 99) ? int'(RepeatForever) : 65534;
               long_voices++;
            end
            if (s < e) fill_range(s, e);
            issue(row(REQ_PLAY, 0, 0, s, e, rep, $urandom_range(0, 65535),
                      $urandom_range(0, 65535)));
         end else begin
            issue(row(REQ_MIX, 0, 0, 0, 0, 0, 0, 0));
         end
      end
      start <= 1'b0;

      while (expected_frames.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (errors == 0) begin
         $display("looping_voice_mixer regression: pass");
      end else begin
         $display("looping_voice_mixer regression: fail");
      end
      $finish;
   end
endmodule
